### src/orbit_camera_eye_position_defines.svh
// ----------------------------------------------------------------------------
// Orbit camera assertion macros
// Concurrent assertion wrappers used by the orbit camera eye position module.
// ----------------------------------------------------------------------------
`ifndef ORBIT_CAMERA_EYE_POSITION_DEFINES_SVH
`define ORBIT_CAMERA_EYE_POSITION_DEFINES_SVH
`ifndef ASSERT_OFF
`define OC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define OC_ASSERT(lbl, clk, rstn, prop, msg)
`define OC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### src/ocep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orbit camera package
// Constants and the arctangent table shared by the camera datapath.
// ----------------------------------------------------------------------------
package ocep_pkg;
  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  localparam logic [1:0] RegRollSpeed = 2'd0;
  localparam logic [1:0] RegOrbitDist = 2'd1;
  localparam logic [1:0] RegPitchMin = 2'd2;
  localparam logic [1:0] RegPitchMax = 2'd3;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sd843314857;
      5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043837;
      5'd3: atan_q30 = 34'sd133525159;
      5'd4: atan_q30 = 34'sd67021687;
      5'd5: atan_q30 = 34'sd33543516;
      5'd6: atan_q30 = 34'sd16775851;
      5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194283;
      5'd9: atan_q30 = 34'sd2097149;
      default: atan_q30 = 34'sd1 <<< (5'd30 - i);
    endcase
  endfunction
endpackage
`default_nettype wire

### src/ocep_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orbit camera CORDIC
// Rotation-mode sine and cosine, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ocep_cordic
  import ocep_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] angle_i,
  output logic                    done_o,
  output logic signed [33:0]      sin_o,
  output logic signed [33:0]      cos_o
);
  logic signed [33:0] x_q, y_q, z_q;
  logic               neg_q, busy_q;
  logic [StepW-1:0]   i_q;
  logic signed [33:0] z0, xs, ys;

  assign z0 = 34'(angle_i) <<< 17;
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      i_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        x_q    <= GainQ30;
        y_q    <= '0;
        if (z0 > HalfPiQ30) begin
          z_q <= z0 - PiQ30; neg_q <= 1'b1;
        end else if (z0 < -HalfPiQ30) begin
          z_q <= z0 + PiQ30; neg_q <= 1'b1;
        end else begin
          z_q <= z0; neg_q <= 1'b0;
        end
      end else if (busy_q) begin
        if (i_q == StepW'(CordicSteps)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
          sin_o  <= neg_q ? -y_q : y_q;
          cos_o  <= neg_q ? -x_q : x_q;
        end else begin
          if (!z_q[33]) begin
            x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_q30(5'(i_q));
          end else begin
            x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_q30(5'(i_q));
          end
          i_q <= i_q + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/orbit_camera_eye_position.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orbit camera eye position
// Updates pitch and yaw from stick input and places the eye on the orbit.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A frame runs through its states in order:
// S_IDLE accepts the beat; S_SPEED, S_PSTEP and S_YSTEP multiply for the
// speed and the two angle steps; S_ANGLE starts the shared CORDIC; S_CP and
// S_CY wait on the two CORDIC passes; S_FX, S_FZ, S_EX, S_EY and S_EZ do one
// multiply each for the forward vector and the three distance products; and
// S_OUT holds the result on the output. The block is not ready while a frame
// is in progress or its result waits to be taken.
`include "orbit_camera_eye_position_defines.svh"
module orbit_camera_eye_position
  import ocep_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // stick_x, stick_y, elapsed_time, target_x, target_y, target_z
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // eye_x, eye_y, eye_z, pitch_now, yaw_now, zero pad
  output logic [135:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [23:0]  cfg_data_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_SPEED, S_PSTEP, S_YSTEP, S_ANGLE, S_CP, S_CY,
    S_FX, S_FZ, S_EX, S_EY, S_EZ, S_OUT
  } state_e;

  state_e             state_q;
  logic [14:0]        roll_q;
  logic [23:0]        dist_q;
  logic signed [14:0] pmin_q, pmax_q;
  logic signed [15:0] pitch_q, yaw_q;
  logic signed [15:0] sx_q, sy_q;
  logic [15:0]        et_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  logic [30:0]        speed_q;
  logic signed [47:0] pstep_q;
  logic signed [33:0] sp_q, cp_q, sy_s_q, cy_q, fx_q, fz_q;
  logic signed [31:0] ex_q, ey_q, ez_q;

  // Shared multiplier: 34 x 34 signed.
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  assign prod = ma * mb;

  logic               cs, cdone;
  logic signed [15:0] cang;
  logic signed [33:0] csin, ccos;
  ocep_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cs), .angle_i(cang),
    .done_o(cdone), .sin_o(csin), .cos_o(ccos)
  );

  function automatic logic signed [15:0] sat_step(input logic signed [67:0] p);
    logic signed [67:0] r;
    r = (p + 68'sd536870912) >>> 30;
    if (r > 68'(PiQ13)) sat_step = PiQ13;
    else if (r < -68'(PiQ13)) sat_step = -PiQ13;
    else sat_step = 16'(r);
  endfunction

  function automatic logic signed [31:0] eye(input logic signed [31:0] t,
                                             input logic signed [67:0] p);
    logic signed [67:0] r;
    r = 68'(t) - ((p + 68'sd2097152) >>> 22);
    if (r > 68'sd2147483647) eye = 32'sh7fffffff;
    else if (r < -68'sd2147483648) eye = 32'sh80000000;
    else eye = 32'(r);
  endfunction

  logic signed [67:0] mq;
  assign mq = (prod + 68'sd536870912) >>> 30;

  logic signed [16:0] pn, yn;
  logic signed [15:0] ps, ys, pc;
  assign ps = 16'(pstep_q);
  assign ys = sat_step(prod);
  assign pn = 17'(pitch_q) + 17'(ps);
  assign yn = 17'(yaw_q) + 17'(ys);

  // The pitch pass is started on leaving S_ANGLE; the yaw pass is started
  // from S_CP in the cycle in which the pitch pass reports done.
  always_comb begin
    ma = '0; mb = '0; cs = 1'b0; cang = pitch_q;
    unique case (state_q)
      S_SPEED: begin ma = 34'(roll_q); mb = 34'(et_q); end
      S_PSTEP: begin ma = 34'(sy_q); mb = 34'(speed_q); end
      S_YSTEP: begin ma = 34'(sx_q); mb = 34'(speed_q); end
      S_CP:    begin cang = yaw_q; end
      S_CY:    begin cang = yaw_q; end
      S_FX:    begin ma = cp_q; mb = sy_s_q; end
      S_FZ:    begin ma = cp_q; mb = cy_q; end
      S_EX:    begin ma = fx_q; mb = 34'(dist_q); end
      S_EY:    begin ma = -sp_q; mb = 34'(dist_q); end
      S_EZ:    begin ma = fz_q; mb = 34'(dist_q); end
      default: ;
    endcase
    if (state_q == S_ANGLE) cs = 1'b1;
    if (state_q == S_CP && cdone) cs = 1'b1;
  end

  always_comb begin
    pc = 16'(pn);
    if (pn > 17'(pmax_q)) pc = 16'(pmax_q);
    if (((pn > 17'(pmax_q)) ? 17'(pmax_q) : pn) < 17'(pmin_q)) pc = 16'(pmin_q);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {9'd0, yaw_q, pitch_q[14:0], ez_q, ey_q, ex_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      roll_q  <= 15'd6434;
      dist_q  <= 24'd2560;
      pmin_q  <= -15'sd6434;
      pmax_q  <= 15'sd6434;
      pitch_q <= '0;
      yaw_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegRollSpeed: roll_q <= cfg_data_i[14:0];
          RegOrbitDist: dist_q <= cfg_data_i;
          RegPitchMin:  pmin_q <= cfg_data_i[14:0];
          RegPitchMax:  pmax_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          {tz_q, ty_q, tx_q, et_q, sy_q, sx_q} <= s_axis_tdata;
          state_q <= S_SPEED;
        end
        S_SPEED: begin speed_q <= 31'(prod); state_q <= S_PSTEP; end
        S_PSTEP: begin pstep_q <= 48'(sat_step(prod)); state_q <= S_YSTEP; end
        S_YSTEP: begin
          pitch_q <= pc;
          if (yn < -17'(PiQ13)) yaw_q <= 16'(yn + TwoPiQ13);
          else if (yn > 17'(PiQ13)) yaw_q <= 16'(yn - TwoPiQ13);
          else yaw_q <= 16'(yn);
          state_q <= S_ANGLE;
        end
        S_ANGLE: state_q <= S_CP;
        S_CP: if (cdone) begin sp_q <= csin; cp_q <= ccos; state_q <= S_CY; end
        S_CY: if (cdone) begin sy_s_q <= csin; cy_q <= ccos; state_q <= S_FX; end
        S_FX: begin fx_q <= 34'(mq); state_q <= S_FZ; end
        S_FZ: begin fz_q <= 34'(mq); state_q <= S_EX; end
        S_EX: begin ex_q <= eye(tx_q, prod); state_q <= S_EY; end
        S_EY: begin ey_q <= eye(ty_q, prod); state_q <= S_EZ; end
        S_EZ: begin ez_q <= eye(tz_q, prod); state_q <= S_OUT; end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `OC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "drop")
  `OC_ASSERT(a_excl, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "ready while pending")
  `OC_ASSERT(a_yaw, clk_i, rst_ni, yaw_q <= PiQ13 && yaw_q >= -PiQ13, "yaw out of range")
endmodule
`default_nettype wire
